FILE: rtl/dslr_pkg.sv
// Shared types and constants for the duty slew-rate limiter.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package dslr_pkg;

  localparam int DUTY_W  = 15;
  localparam int TICK_W  = 16;
  localparam int SPEED_W = 16;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = SPEED_W + DUTY_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_STEP = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_INIT = 2'd2
  } kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BIG_STEP   = 3'd0,
    REG_SMALL_STEP = 3'd1,
    REG_GAP_THRESH = 3'd2,
    REG_RAMP_PER   = 3'd3,
    REG_FULL_SCALE = 3'd4
  } reg_idx_t;

  localparam logic [DUTY_W-1:0] BIG_STEP_RST   = 15'd100;
  localparam logic [DUTY_W-1:0] SMALL_STEP_RST = 15'd10;
  localparam logic [DUTY_W-1:0] GAP_THRESH_RST = 15'd500;
  localparam logic [TICK_W-1:0] RAMP_PER_RST   = 16'd1;
  localparam logic [DUTY_W-1:0] FULL_SCALE_RST = 15'd4000;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SPEED_W-1:0] speed_target;
    logic [TICK_W-1:0]  now_ms;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              duty_written;
  } res_t;

  typedef struct packed {
    logic [DUTY_W-1:0] big_step;
    logic [DUTY_W-1:0] small_step;
    logic [DUTY_W-1:0] gap_threshold;
    logic [TICK_W-1:0] ramp_period;
    logic [DUTY_W-1:0] duty_full_scale;
  } cfg_t;

  // Request after the front stage: the target duty is already scaled.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TICK_W-1:0] now_ms;
    logic [DUTY_W-1:0] target;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/dslr_cfg.sv
// Configuration register bank of the duty slew-rate limiter.
// Depends on dslr_pkg for the register indexes and reset values.
`default_nettype none

module dslr_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [dslr_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [dslr_pkg::CFG_W-1:0]   cfg_data,
  output dslr_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.big_step        <= dslr_pkg::BIG_STEP_RST;
      cfg.small_step      <= dslr_pkg::SMALL_STEP_RST;
      cfg.gap_threshold   <= dslr_pkg::GAP_THRESH_RST;
      cfg.ramp_period     <= dslr_pkg::RAMP_PER_RST;
      cfg.duty_full_scale <= dslr_pkg::FULL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dslr_pkg::REG_BIG_STEP:   cfg.big_step        <= cfg_data[dslr_pkg::DUTY_W-1:0];
        dslr_pkg::REG_SMALL_STEP: cfg.small_step      <= cfg_data[dslr_pkg::DUTY_W-1:0];
        dslr_pkg::REG_GAP_THRESH: cfg.gap_threshold   <= cfg_data[dslr_pkg::DUTY_W-1:0];
        dslr_pkg::REG_RAMP_PER:   cfg.ramp_period     <= cfg_data[dslr_pkg::TICK_W-1:0];
        dslr_pkg::REG_FULL_SCALE: cfg.duty_full_scale <= cfg_data[dslr_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dslr_front.sv
// Input stage: registers each request together with its scaled target duty.
// Depends on dslr_pkg for the request and stage types.
`default_nettype none

module dslr_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           take,
  input  wire logic                           advance,
  input  wire dslr_pkg::cmd_t                 cmd,
  input  wire logic [dslr_pkg::DUTY_W-1:0]    duty_full_scale,
  output logic                                s1_valid,
  output dslr_pkg::stage_t                    s1
);

  logic [dslr_pkg::PROD_W-1:0] prod;

  // A Q16 speed times a 15-bit full scale, shifted down by 16, always fits in
  // the duty width, so the saturation of the target never engages.
  assign prod = dslr_pkg::PROD_W'(cmd.speed_target) * dslr_pkg::PROD_W'(duty_full_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.kind   <= cmd.kind;
      s1.now_ms <= cmd.now_ms;
      s1.target <= prod[dslr_pkg::PROD_W-1:dslr_pkg::SPEED_W];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dslr_update.sv
// Update stage: holds the duty and tick state, registers the result, and
// applies one request per cycle unless the result stalls. Depends on dslr_pkg.
`default_nettype none

module dslr_update (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s1_valid,
  input  wire dslr_pkg::stage_t s1,
  input  wire dslr_pkg::cfg_t   cfg,
  input  wire logic             res_stall,
  output logic                  advance,
  output logic                  res_valid,
  output dslr_pkg::res_t        res
);

  logic [dslr_pkg::DUTY_W-1:0] duty_level;
  logic [dslr_pkg::DUTY_W-1:0] duty_level_next;
  logic [dslr_pkg::TICK_W-1:0] tick_mark;
  logic [dslr_pkg::TICK_W-1:0] tick_mark_next;
  logic                        written_next;
  logic                        moves;
  logic [dslr_pkg::TICK_W-1:0] elapsed;
  logic                        rising;
  logic [dslr_pkg::DUTY_W-1:0] gap;
  logic [dslr_pkg::DUTY_W-1:0] step_raw;
  logic [dslr_pkg::DUTY_W-1:0] step;

  assign advance = !res_valid || !res_stall;
  assign moves   = s1_valid && advance;

  // The subtraction wraps at the tick width, which handles tick rollover.
  assign elapsed  = s1.now_ms - tick_mark;
  assign rising   = s1.target > duty_level;
  assign gap      = rising ? (s1.target - duty_level) : (duty_level - s1.target);
  assign step_raw = (gap > cfg.gap_threshold) ? cfg.big_step : cfg.small_step;
  assign step     = (step_raw > gap) ? gap : step_raw;

  always_comb begin
    duty_level_next = duty_level;
    tick_mark_next  = tick_mark;
    written_next    = 1'b0;
    case (s1.kind)
      dslr_pkg::KIND_ZERO: begin
        duty_level_next = '0;
        written_next    = 1'b1;
      end
      dslr_pkg::KIND_INIT: begin
        duty_level_next = '0;
        tick_mark_next  = s1.now_ms;
        written_next    = 1'b1;
      end
      dslr_pkg::KIND_STEP: begin
        if (elapsed >= cfg.ramp_period) begin
          tick_mark_next = s1.now_ms;
          // A zero step still counts as a write to the PWM.
          if (s1.target != duty_level) begin
            duty_level_next = rising ? (duty_level + step) : (duty_level - step);
            written_next    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level <= '0;
      tick_mark  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (moves) begin
        duty_level <= duty_level_next;
        tick_mark  <= tick_mark_next;
        res_valid  <= 1'b1;
      end else if (!res_stall) begin
        res_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (moves) begin
      res.duty         <= duty_level_next;
      res.duty_written <= written_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/duty_slew_rate_limiter.sv
// Duty slew-rate limiter: takes one request per clock while the result side
// does not stall and returns one result per request via the front-stage and
// output registers. The first stage scales the Q16 speed target by the
// full-scale duty; the second stage holds the current duty and last tick,
// and its state update sets that rate. One request can still enter the front
// stage while an earlier result waits in the output register.
// Depends on dslr_pkg, dslr_cfg, dslr_front and dslr_update.
`default_nettype none

module duty_slew_rate_limiter (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output logic                              cmd_stall,
  input  wire dslr_pkg::cmd_t               cmd,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output dslr_pkg::res_t                    res,
  input  wire logic                         cfg_we,
  input  wire logic [dslr_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [dslr_pkg::CFG_W-1:0]   cfg_data
);

  dslr_pkg::cfg_t   cfg;
  dslr_pkg::stage_t s1;
  logic             s1_valid;
  logic             advance;
  logic             take;

  assign cmd_stall = s1_valid && !advance;
  assign take      = cmd_valid && !cmd_stall;

  dslr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dslr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .advance         (advance),
    .cmd             (cmd),
    .duty_full_scale (cfg.duty_full_scale),
    .s1_valid        (s1_valid),
    .s1              (s1)
  );

  dslr_update u_update (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .cfg       (cfg),
    .res_stall (res_stall),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: dv/tb_duty_slew_rate_limiter.sv
// Self-checking testbench for duty_slew_rate_limiter: directed and random requests
// under several register settings, each result checked against a predicted duty.
// Depends on dslr_pkg and the RTL under rtl.
module tb_duty_slew_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import dslr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
  localparam int Q_FRAC = 16;
  localparam int HOLD_OFF_CYCLES = 120;
  // Longest legal quiet stretch is the long hold-off plus one sender gap.
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 130;

  class duty_ramp_checker;
    cfg_t regs;
    logic [DUTY_W-1:0] duty;
    logic [TICK_W-1:0] tick_mark;
    res_t expected_duty_q[$];
    int errors;
    int requests;
    int results;
    int writes;

    function new();
      regs.big_step = BIG_STEP_RST;
      regs.small_step = SMALL_STEP_RST;
      regs.gap_threshold = GAP_THRESH_RST;
      regs.ramp_period = RAMP_PER_RST;
      regs.duty_full_scale = FULL_SCALE_RST;
      duty = '0;
      tick_mark = '0;
      errors = 0;
      requests = 0;
      results = 0;
      writes = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_BIG_STEP:   regs.big_step = v[DUTY_W-1:0];
        REG_SMALL_STEP: regs.small_step = v[DUTY_W-1:0];
        REG_GAP_THRESH: regs.gap_threshold = v[DUTY_W-1:0];
        REG_RAMP_PER:   regs.ramp_period = v[TICK_W-1:0];
        REG_FULL_SCALE: regs.duty_full_scale = v[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the duty and tick state by one request and returns its result.
    function res_t next_duty(cmd_t c);
      logic [31:0] prod;
      logic [DUTY_W-1:0] tgt;
      logic [DUTY_W-1:0] gap;
      logic [DUTY_W-1:0] stride;
      logic [TICK_W-1:0] elapsed;
      res_t r;
      r.duty_written = 1'b0;
      case (c.kind)
        KIND_ZERO: begin
          duty = '0;
          r.duty_written = 1'b1;
        end
        KIND_INIT: begin
          duty = '0;
          tick_mark = c.now_ms;
          r.duty_written = 1'b1;
        end
        KIND_STEP: begin
          prod = 32'(c.speed_target) * 32'(regs.duty_full_scale);
          if ((prod >> Q_FRAC) > 32'(DUTY_MAX)) begin
            tgt = DUTY_MAX;
          end else begin
            tgt = prod[Q_FRAC +: DUTY_W];
          end
          // The tick difference wraps at the tick width.
          elapsed = c.now_ms - tick_mark;
          if (elapsed >= regs.ramp_period) begin
            tick_mark = c.now_ms;
            if (tgt != duty) begin
              gap = (tgt > duty) ? tgt - duty : duty - tgt;
              stride = (gap > regs.gap_threshold) ? regs.big_step : regs.small_step;
              if (stride > gap) stride = gap;
              duty = (tgt > duty) ? duty + stride : duty - stride;
              r.duty_written = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.duty = duty;
      return r;
    endfunction

    function void take_request(cmd_t c);
      expected_duty_q.push_back(next_duty(c));
      requests++;
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (got.duty_written) writes++;
      if (expected_duty_q.size() == 0) begin
        $error("result with no request pending: duty=%0d duty_written=%0b",
               got.duty, got.duty_written);
        errors++;
        return;
      end
      want = expected_duty_q.pop_front();
      if (got.duty !== want.duty) begin
        $error("duty: expected %0d, got %0d", want.duty, got.duty);
        errors++;
      end
      if (got.duty_written !== want.duty_written) begin
        $error("duty_written: expected %0b, got %0b", want.duty_written, got.duty_written);
        errors++;
      end
    endfunction

    function int pending();
      return expected_duty_q.size();
    endfunction

    function void close_out();
      if (expected_duty_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_duty_q.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  duty_ramp_checker duty_chk = new();

  bit quiet_tail = 1'b0;
  bit hold_off_req = 1'b0;
  int idle_cycles = 0;
  int settings_used = 1;
  int calm_left = 0;
  logic [TICK_W-1:0] gen_tick = '0;
  logic [SPEED_W-1:0] gen_speed = '0;

  duty_slew_rate_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, free stretches, and one long hold-off on request.
  initial begin
    int len;
    bit holding;
    forever begin
      @(posedge clk);
      holding = hold_off_req;
      if (holding) begin
        res_stall <= 1'b1;
        len = HOLD_OFF_CYCLES;
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        len = $urandom_range(1, 14);
      end else begin
        res_stall <= 1'b0;
        len = $urandom_range(1, 30);
      end
      repeat (len - 1) @(posedge clk);
      if (holding) hold_off_req = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) duty_chk.check_result(res);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("duty_slew_rate_limiter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_t mk_request(logic [KIND_W-1:0] k, logic [SPEED_W-1:0] s,
                                      logic [TICK_W-1:0] t);
    cmd_t c;
    c.kind = k;
    c.speed_target = s;
    c.now_ms = t;
    return c;
  endfunction

  // Mostly step requests that hold a target for a while, with ticks placed at,
  // just short of, or past the ramp period; init, force-zero and the unused kind
  // are mixed in as noise.
  function automatic cmd_t random_request();
    cmd_t c;
    int pick;
    int ramp;
    ramp = int'(duty_chk.regs.ramp_period);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: gen_speed = '0;
        1: gen_speed = '1;
        default: gen_speed = SPEED_W'($urandom);
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1: gen_tick = duty_chk.tick_mark + duty_chk.regs.ramp_period;
      2: gen_tick = duty_chk.tick_mark + duty_chk.regs.ramp_period - 1'b1;
      3: gen_tick = TICK_W'($urandom);
      4: ;
      default: gen_tick = gen_tick + TICK_W'($urandom_range(0, 2 * ramp + 2));
    endcase
    c.speed_target = gen_speed;
    c.now_ms = gen_tick;
    if (pick < 84) begin
      c.kind = KIND_STEP;
    end else if (pick < 90) begin
      c.kind = KIND_INIT;
    end else if (pick < 95) begin
      c.kind = KIND_ZERO;
    end else begin
      c.kind = KIND_UNUSED;
      c.speed_target = SPEED_W'($urandom);
      c.now_ms = TICK_W'($urandom);
    end
    return c;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t s;
    case (p)
      0: begin
        s.big_step = '1;
        s.small_step = '1;
        s.gap_threshold = '1;
        s.ramp_period = '1;
        s.duty_full_scale = '1;
      end
      1: s = '0;
      2: begin
        s = '0;
        s.big_step = 15'd1;
        s.small_step = 15'd1;
        s.duty_full_scale = '1;
      end
      3: begin
        s.big_step = BIG_STEP_RST;
        s.small_step = SMALL_STEP_RST;
        s.gap_threshold = GAP_THRESH_RST;
        s.ramp_period = RAMP_PER_RST;
        s.duty_full_scale = FULL_SCALE_RST;
      end
      default: begin
        s.big_step = ($urandom_range(0, 2) == 0) ? DUTY_W'($urandom)
                                                 : DUTY_W'($urandom_range(1, 400));
        s.small_step = DUTY_W'($urandom_range(0, 60));
        s.gap_threshold = ($urandom_range(0, 2) == 0) ? DUTY_W'($urandom)
                                                      : DUTY_W'($urandom_range(0, 1500));
        s.ramp_period = ($urandom_range(0, 4) == 0) ? TICK_W'($urandom)
                                                    : TICK_W'($urandom_range(0, 5));
        s.duty_full_scale = DUTY_W'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic send_request(input cmd_t c);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    duty_chk.take_request(c);
  endtask

  // Sender gaps come in bursts, with calm stretches in between.
  task automatic pace();
    if (calm_left > 0) begin
      calm_left--;
    end else if (!quiet_tail && !hold_off_req) begin
      if ($urandom_range(0, 9) == 0) begin
        calm_left = $urandom_range(20, 60);
      end else if ($urandom_range(0, 2) == 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle(input int settle);
    cmd_valid <= 1'b0;
    while (duty_chk.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    reg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_BIG_STEP:   cfg_data <= CFG_W'(s.big_step);
        REG_SMALL_STEP: cfg_data <= CFG_W'(s.small_step);
        REG_GAP_THRESH: cfg_data <= CFG_W'(s.gap_threshold);
        REG_RAMP_PER:   cfg_data <= CFG_W'(s.ramp_period);
        REG_FULL_SCALE: cfg_data <= CFG_W'(s.duty_full_scale);
        default: cfg_data <= '0;
      endcase
      @(posedge clk);
      duty_chk.set_reg(idx, cfg_data);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_requests(input cmd_t reqs[$]);
    foreach (reqs[i]) begin
      send_request(reqs[i]);
      pace();
    end
  endtask

  initial begin
    cmd_t directed[$];
    cfg_t zero_steps;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: full speed maps to a target of 3999.
    directed = '{
      mk_request(KIND_INIT, 16'h0000, 16'hFFFE),
      mk_request(KIND_STEP, 16'hFFFF, 16'hFFFE),  // period not reached
      mk_request(KIND_STEP, 16'hFFFF, 16'h0000),  // tick wraps, big step up
      mk_request(KIND_STEP, 16'hFFFF, 16'h0001),
      mk_request(KIND_STEP, 16'h0000, 16'h0002),  // small step down
      mk_request(KIND_STEP, 16'h0000, 16'h0000),  // tick behind the last one
      mk_request(KIND_ZERO, 16'hFFFF, 16'hFFFF),
      mk_request(KIND_STEP, 16'h0000, 16'h0005),  // already at target
      mk_request(KIND_STEP, 16'h0001, 16'h0006),  // target rounds down to zero
      mk_request(KIND_UNUSED, 16'hFFFF, 16'hFFFF),
      mk_request(KIND_STEP, 16'h0800, 16'h0007),
      mk_request(KIND_STEP, 16'h8000, 16'h0007),
      mk_request(KIND_STEP, 16'h8000, 16'h0008),
      mk_request(KIND_INIT, 16'hAAAA, 16'h5555),
      mk_request(KIND_STEP, 16'hAAAA, 16'h5556),
      mk_request(KIND_STEP, 16'h5555, 16'hAAAA)
    };
    run_requests(directed);

    // Zero ramp period and zero step sizes: the duty is rewritten without moving.
    wait_idle(4);
    zero_steps = '0;
    zero_steps.duty_full_scale = '1;
    apply_settings(zero_steps);
    directed = '{
      mk_request(KIND_INIT, 16'h0000, 16'h1234),
      mk_request(KIND_STEP, 16'hFFFF, 16'h1234),
      mk_request(KIND_STEP, 16'h0000, 16'h1234),
      mk_request(KIND_UNUSED, 16'h0000, 16'h0000)
    };
    run_requests(directed);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle(4);
      if (p == RANDOM_PHASES - 1) quiet_tail = 1'b1;
      apply_settings(phase_settings(p));
      if (p == 4) hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        send_request(random_request());
        pace();
      end
    end

    wait_idle(8);
    duty_chk.close_out();
    $display("Sent %0d requests and checked %0d results, %0d of them duty writes,",
             duty_chk.requests, duty_chk.results, duty_chk.writes);
    $display("across %0d register settings, including a %0d-cycle result hold-off.",
             settings_used, HOLD_OFF_CYCLES);
    if (duty_chk.errors == 0) begin
      $display("duty_slew_rate_limiter regression: pass");
    end else begin
      $display("duty_slew_rate_limiter regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dslr_pkg.sv
rtl/dslr_cfg.sv
rtl/dslr_front.sv
rtl/dslr_update.sv
rtl/duty_slew_rate_limiter.sv
dv/tb_duty_slew_rate_limiter.sv
